// ===== src/tpw_pkg.sv =====
// Shared types and constants for the two-level page walker.
// Used by tpw_step and by the two_level_page_walker top level; no dependencies.
package tpw_pkg;

  localparam int unsigned AddrW   = 32;
  localparam int unsigned FrameW  = 20;
  localparam int unsigned BigOffW = 22;
  localparam int unsigned SmlOffW = 12;
  localparam int unsigned CfgAddrW = 3;

  localparam logic [AddrW-1:0] BigSize   = 32'h0040_0000;
  localparam logic [AddrW-1:0] SmallSize = 32'h0000_1000;

  localparam int unsigned EntPresentBit = 0;
  localparam int unsigned EntBigBit     = 7;

  // Register byte offsets on the configuration port
  localparam logic [CfgAddrW-1:0] RegDirBase = 3'd0;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_FAULT = 2'd2
  } tpw_kind_t;

  typedef enum logic [2:0] {
    PHASE_IDLE = 3'b001,
    PHASE_DIR  = 3'b010,
    PHASE_TBL  = 3'b100
  } tpw_phase_t;

  typedef struct packed {
    logic             req_type;
    logic [AddrW-1:0] vaddr;
    logic [AddrW-1:0] vlen;
    logic [AddrW-1:0] read_data;
  } tpw_item_t;

  typedef struct packed {
    tpw_kind_t        result_kind;
    logic [AddrW-1:0] read_addr;
    logic [AddrW-1:0] paddr;
    logic [AddrW-1:0] plen;
    logic             big_page;
  } tpw_result_t;

endpackage

// ===== src/tpw_step.sv =====
// Walk state and the combinational walk step: one item in, at most one result out.
// Depends on tpw_pkg.
module tpw_step (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step_en,
  input  tpw_pkg::tpw_item_t            item,
  input  logic [tpw_pkg::FrameW-1:0]    dir_base_frame,
  output logic                          res_vld,
  output tpw_pkg::tpw_result_t          res
);
  import tpw_pkg::*;

  tpw_phase_t        phase_r, phase_nxt;
  logic [AddrW-1:0]  held_vaddr_r, held_vaddr_nxt;
  logic [AddrW-1:0]  held_vlen_r, held_vlen_nxt;

  logic [BigOffW-1:0] big_off;
  logic [SmlOffW-1:0] sml_off;
  logic [AddrW:0]     big_end, sml_end;
  logic [AddrW-1:0]   big_clip, sml_clip;
  logic               ent_present, ent_big;

  assign big_off = held_vaddr_r[BigOffW-1:0];
  assign sml_off = held_vaddr_r[SmlOffW-1:0];

  // Length sums are one bit wider so they never wrap
  assign big_end  = {1'b0, held_vlen_r} + (AddrW+1)'(big_off);
  assign sml_end  = {1'b0, held_vlen_r} + (AddrW+1)'(sml_off);
  assign big_clip = (big_end > {1'b0, BigSize}) ? BigSize - AddrW'(big_off) : held_vlen_r;
  assign sml_clip = (sml_end > {1'b0, SmallSize}) ? SmallSize - AddrW'(sml_off) : held_vlen_r;

  assign ent_present = item.read_data[EntPresentBit];
  assign ent_big     = item.read_data[EntBigBit];

  always_comb begin
    res_vld        = 1'b0;
    res            = '0;
    res.result_kind = KIND_READ;
    phase_nxt      = phase_r;
    held_vaddr_nxt = held_vaddr_r;
    held_vlen_nxt  = held_vlen_r;
    if (!item.req_type) begin
      // New request: drop any walk in progress and fetch the directory entry
      held_vaddr_nxt = item.vaddr;
      held_vlen_nxt  = item.vlen;
      phase_nxt      = PHASE_DIR;
      res_vld        = 1'b1;
      res.result_kind = KIND_READ;
      res.read_addr  = {dir_base_frame, item.vaddr[AddrW-1:BigOffW], 2'b00};
    end else begin
      unique case (phase_r)
        PHASE_DIR: begin
          res_vld = 1'b1;
          if (!ent_present) begin
            phase_nxt       = PHASE_IDLE;
            res.result_kind = KIND_FAULT;
          end else if (ent_big) begin
            phase_nxt       = PHASE_IDLE;
            res.result_kind = KIND_DONE;
            res.paddr       = {item.read_data[AddrW-1:BigOffW], big_off};
            res.plen        = big_clip;
            res.big_page    = 1'b1;
          end else begin
            phase_nxt       = PHASE_TBL;
            res.result_kind = KIND_READ;
            res.read_addr   = {item.read_data[AddrW-1:SmlOffW],
                               held_vaddr_r[BigOffW-1:SmlOffW], 2'b00};
          end
        end
        PHASE_TBL: begin
          res_vld   = 1'b1;
          phase_nxt = PHASE_IDLE;
          if (!ent_present) begin
            res.result_kind = KIND_FAULT;
          end else begin
            res.result_kind = KIND_DONE;
            res.paddr       = {item.read_data[AddrW-1:SmlOffW], sml_off};
            res.plen        = sml_clip;
          end
        end
        default: begin
          // Response with no walk open: drop it
          phase_nxt = PHASE_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PHASE_IDLE;
      held_vaddr_r <= '0;
      held_vlen_r  <= '0;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      held_vaddr_r <= held_vaddr_nxt;
      held_vlen_r  <= held_vlen_nxt;
    end
  end

endmodule

// ===== src/two_level_page_walker.sv =====
// Two-level page walker top level: input register, walk step, result register,
// and the configuration register port. Depends on tpw_pkg and tpw_step.
//
// Two-level page-table walker with 4MB big pages. Each transfer on the in_
// channel is either a new translation request (in_tuser = 0, with vaddr and vlen)
// or a memory read response (in_tuser = 1, with the entry word). A request always
// yields a read request for the directory entry; a response yields a read request
// for the table entry, a finished translation (physical address, big_page flag and
// the length clipped to the end of the page), or a not-present fault. A request
// during a walk drops that walk; a response with no walk open gives no result.
// The block takes one item per cycle, back to back, while out_ is not stalled; an
// item passes through the input register, the combinational walk step and the
// result register, whose output is offered on out_. Backpressure on out_ stalls
// both registers together. dir_base_frame sits at byte address 0 and must only
// be written while no walk item is in flight.
module two_level_page_walker (
  input  logic                         clk,
  input  logic                         rst_n,
  // in_tdata: [31:0] vaddr, [63:32] vlen, [95:64] read_data
  input  logic [95:0]                  in_tdata,
  // in_tuser: [0] req_type
  input  logic                         in_tuser,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // out_tdata: [31:0] read_addr, [63:32] paddr, [95:64] plen, [96] big_page,
  // [103:97] zero
  output logic [103:0]                 out_tdata,
  // out_tuser: [1:0] result_kind
  output logic [1:0]                   out_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [tpw_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);
  import tpw_pkg::*;

  logic                s1_v_r;
  tpw_item_t           s1_item_r;
  logic                out_v_r;
  tpw_result_t         out_res_r;
  logic [FrameW-1:0]   dir_base_r;

  logic                adv;
  logic                step_en;
  logic                res_vld;
  tpw_result_t         res;
  logic                cfg_wr;
  logic                cfg_hit;

  // Configuration port: zero-wait APB, one register
  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[CfgAddrW-1:2] == RegDirBase[CfgAddrW-1:2]);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready & cfg_hit;
  assign cfg_prdata = cfg_hit ? {12'd0, dir_base_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_base_r <= '0;
    end else if (cfg_wr) begin
      dir_base_r <= cfg_pwdata[FrameW-1:0];
    end
  end

  // Advance the pipe whenever the result register is free or being drained
  assign adv       = !out_v_r || out_tready;
  assign in_tready = !s1_v_r || adv;
  assign step_en   = s1_v_r && adv;

  // Input register: hold the item until the step consumes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      s1_item_r.req_type  <= in_tuser;
      s1_item_r.vaddr     <= in_tdata[31:0];
      s1_item_r.vlen      <= in_tdata[63:32];
      s1_item_r.read_data <= in_tdata[95:64];
    end
  end

  tpw_step u_step (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_en        (step_en),
    .item           (s1_item_r),
    .dir_base_frame (dir_base_r),
    .res_vld        (res_vld),
    .res            (res)
  );

  // Result register: a dropped response leaves it empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= step_en && res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_res_r.result_kind;
  assign out_tdata  = {7'd0, out_res_r.big_page, out_res_r.plen,
                       out_res_r.paddr, out_res_r.read_addr};

`ifndef NO_ASSERTIONS
  // A new request always produces a directory read on the next cycle
  a_req_gives_read: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && !s1_item_r.req_type) |=> (out_tvalid && out_tuser == KIND_READ))
    else $error("request did not produce a read result");

  // Input can only stall when both registers are occupied
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_v_r && out_v_r && !out_tready))
    else $error("input stalled with room in the pipe");

  // Big-page flag only on a finished translation
  a_big_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_res_r.big_page) |-> (out_tuser == KIND_DONE))
    else $error("big_page set on a non-done result");

  // Clipped length never runs past the page
  a_plen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_DONE) |->
      (out_res_r.big_page ? (out_res_r.plen <= BigSize) : (out_res_r.plen <= SmallSize)))
    else $error("plen exceeds page size");
`endif

endmodule

// ===== tb/sv/two_level_page_walker_checker.sv =====
// Scoreboard for the two-level page walker: follows the in_, out_ and cfg_ ports,
// predicts each walk step and compares every out_ transfer with the oldest forecast.
// Depends on tpw_pkg for the result kinds, walk phases and entry bit positions.
module two_level_page_walker_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [95:0]                  in_tdata,
  input  logic                         in_tuser,
  input  logic                         in_tvalid,
  input  logic                         in_tready,
  input  logic [103:0]                 out_tdata,
  input  logic [1:0]                   out_tuser,
  input  logic                         out_tvalid,
  input  logic                         out_tready,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [tpw_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  input  logic                         cfg_pready,
  output int                           fail_count,
  output int                           results_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import tpw_pkg::*;

  tpw_result_t      expected_walk_results[$];
  tpw_phase_t       walk_state;
  logic [AddrW-1:0] held_vaddr;
  logic [AddrW-1:0] held_vlen;
  logic [FrameW-1:0] dir_frame;
  int               mismatch_count;
  tpw_result_t      forecast;
  tpw_result_t      want;
  bit               forecast_valid;

  assign fail_count = mismatch_count;

  initial begin
    mismatch_count      = 0;
    results_outstanding = 0;
  end

  function automatic logic [AddrW-1:0] clip_to_page(logic [AddrW-1:0] off,
                                                    logic [AddrW-1:0] size);
    logic [AddrW:0] span;
    span = {1'b0, held_vlen} + {1'b0, off};
    if (span > {1'b0, size}) return size - off;
    return held_vlen;
  endfunction

  // Advance the walk by one accepted item; flag whether it yields a result.
  task automatic predict_walk(input logic rtype, input logic [AddrW-1:0] vaddr,
                              input logic [AddrW-1:0] vlen, input logic [AddrW-1:0] entry,
                              output bit produced, output tpw_result_t res);
    logic [AddrW-1:0] off;
    res      = '0;
    produced = 1'b1;
    if (rtype == 1'b0) begin
      held_vaddr = vaddr;
      held_vlen  = vlen;
      walk_state = PHASE_DIR;
      res.result_kind = KIND_READ;
      res.read_addr   = {dir_frame, vaddr[31:22], 2'b00};
    end else if (walk_state == PHASE_DIR) begin
      if (!entry[EntPresentBit]) begin
        walk_state = PHASE_IDLE;
        res.result_kind = KIND_FAULT;
      end else if (entry[EntBigBit]) begin
        walk_state = PHASE_IDLE;
        off = {10'd0, held_vaddr[BigOffW-1:0]};
        res.result_kind = KIND_DONE;
        res.paddr       = {entry[31:BigOffW], {BigOffW{1'b0}}} + off;
        res.plen        = clip_to_page(off, BigSize);
        res.big_page    = 1'b1;
      end else begin
        walk_state = PHASE_TBL;
        res.result_kind = KIND_READ;
        res.read_addr   = {entry[31:SmlOffW], {SmlOffW{1'b0}}}
                        + {20'd0, held_vaddr[21:12], 2'b00};
      end
    end else if (walk_state == PHASE_TBL) begin
      walk_state = PHASE_IDLE;
      if (!entry[EntPresentBit]) begin
        res.result_kind = KIND_FAULT;
      end else begin
        off = {20'd0, held_vaddr[SmlOffW-1:0]};
        res.result_kind = KIND_DONE;
        res.paddr       = {entry[31:SmlOffW], {SmlOffW{1'b0}}} + off;
        res.plen        = clip_to_page(off, SmallSize);
      end
    end else begin
      // stray response with no walk open
      walk_state = PHASE_IDLE;
      produced   = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input logic [AddrW-1:0] exp_val,
                             input logic [AddrW-1:0] got_val);
    if (exp_val !== got_val) begin
      $display("%0t ns: %s mismatch, expected 0x%08h, got 0x%08h",
               $time, name, exp_val, got_val);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_walk_results.delete();
      walk_state = PHASE_IDLE;
      held_vaddr = '0;
      held_vlen  = '0;
      dir_frame  = '0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_walk_results.size() == 0) begin
          $display("%0t ns: result with none expected, got kind %0d tdata 0x%026h",
                   $time, out_tuser, out_tdata);
          mismatch_count++;
        end else begin
          want = expected_walk_results.pop_front();
          check_field("result_kind", 32'(want.result_kind), 32'(out_tuser));
          check_field("read_addr", want.read_addr, out_tdata[31:0]);
          check_field("paddr", want.paddr, out_tdata[63:32]);
          check_field("plen", want.plen, out_tdata[95:64]);
          check_field("big_page", 32'(want.big_page), 32'(out_tdata[96]));
        end
      end
      if (in_tvalid && in_tready) begin
        predict_walk(in_tuser, in_tdata[31:0], in_tdata[63:32], in_tdata[95:64],
                     forecast_valid, forecast);
        if (forecast_valid) expected_walk_results.push_back(forecast);
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[CfgAddrW-1:2] == RegDirBase[CfgAddrW-1:2])
        dir_frame = cfg_pwdata[FrameW-1:0];
    end
    results_outstanding <= expected_walk_results.size();
  end

endmodule

// ===== tb/sv/two_level_page_walker_tb.sv =====
// Top of the page walker testbench: clock, reset, walk stimulus, result stalls,
// register writes and the verdict. Depends on tpw_pkg, two_level_page_walker and
// two_level_page_walker_checker.
module two_level_page_walker_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tpw_pkg::*;

  localparam int  LimitCycles = 400000;
  localparam int  DrainCycles = 8;     // covers the two register stages plus slack
  localparam int  PhaseCount  = 5;
  localparam int  ItemsPerPhase = 170;
  localparam int  HoldOffCycles = 300;
  localparam logic ReqNew  = 1'b0;
  localparam logic ReqResp = 1'b1;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic [95:0]         in_tdata = '0;   // [31:0] vaddr, [63:32] vlen, [95:64] read_data
  logic                in_tuser = 1'b0; // [0] req_type
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [103:0]        out_tdata;       // [31:0] read_addr, [63:32] paddr, [95:64] plen,
                                        // [96] big_page, [103:97] zero
  logic [1:0]          out_tuser;       // [1:0] result_kind
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [CfgAddrW-1:0] cfg_paddr = '0;
  logic [31:0]         cfg_pwdata = '0;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  int fail_count;
  int results_outstanding;
  int cycle_count = 0;
  int burst_left = 0;
  int walk_items = 0;
  logic [FrameW-1:0] frame_plan[PhaseCount];

  two_level_page_walker u_dut (
    .clk, .rst_n,
    .in_tdata, .in_tuser, .in_tvalid, .in_tready,
    .out_tdata, .out_tuser, .out_tvalid, .out_tready,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  two_level_page_walker_checker u_check (
    .clk, .rst_n,
    .in_tdata, .in_tuser, .in_tvalid, .in_tready,
    .out_tdata, .out_tuser, .out_tvalid, .out_tready,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .fail_count, .results_outstanding
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake or a result that never shows up ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LimitCycles) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Offer one item and hold it until the transfer. Bursts of random length are
  // separated by random gaps; some bursts follow the previous one with no gap.
  task automatic send_item(input logic rtype, input logic [31:0] va,
                           input logic [31:0] vl, input logic [31:0] rd,
                           input bit counted);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= rtype;
    in_tdata  <= {rd, vl, va};
    do @(posedge clk); while (!in_tready);
    burst_left--;
    if (counted) walk_items++;
  endtask

  // Drop valid and let every forecast result arrive, then let stray
  // responses still in the pipeline flush out.
  task automatic drain;
    in_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (results_outstanding != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_dir_base(input logic [FrameW-1:0] frame);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= RegDirBase;
    cfg_pwdata  <= {12'd0, frame};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Addresses often land near the end of a 4KB or 4MB page to exercise the clip.
  function automatic logic [31:0] pick_vaddr();
    logic [31:0] va;
    va = $urandom;
    case ($urandom_range(0, 3))
      0: va[11:0] = 12'hFFF - 12'($urandom_range(0, 15));
      1: va[21:0] = 22'h3FFFFF - 22'($urandom_range(0, 4095));
      default: ;
    endcase
    return va;
  endfunction

  function automatic logic [31:0] pick_vlen();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(1, 64);
      3: return $urandom_range(0, 32'h2000);
      4: return $urandom_range(0, 32'h80_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_entry(input bit big);
    logic [31:0] e;
    e = $urandom;
    e[EntPresentBit] = ($urandom_range(0, 9) != 0);
    e[EntBigBit]     = big;
    return e;
  endfunction

  // One full walk from a new request; noisy walks use raw random entry words.
  task automatic run_walk(input bit noisy);
    logic [31:0] va;
    logic [31:0] pde;
    logic [31:0] pte;
    va = pick_vaddr();
    send_item(ReqNew, va, pick_vlen(), $urandom, 1'b1);
    pde = noisy ? $urandom : pick_entry($urandom_range(0, 4) < 2);
    send_item(ReqResp, $urandom, $urandom, pde, 1'b1);
    if (pde[EntPresentBit] && !pde[EntBigBit]) begin
      pte = noisy ? $urandom : pick_entry($urandom_range(0, 1) == 1);
      send_item(ReqResp, $urandom, $urandom, pte, 1'b1);
    end
  endtask

  // Receiver: stall on a changing pattern, with one long hold-off while the
  // sender keeps offering so the walker fills up and drops in_tready.
  initial begin : receiver
    int mode;
    int span;
    int seg;
    seg = 0;
    @(posedge clk iff rst_n);
    forever begin
      seg++;
      if (seg == 6) begin
        out_tready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      for (int i = 0; i < span; i++) begin
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 1) == 1);
          2: out_tready <= (i % 3) != 0;
          default: out_tready <= ($urandom_range(0, 4) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int pick;
    frame_plan = '{20'h00000, 20'hFFFFF, 20'h00000, 20'h80000, 20'h00001};
    frame_plan[2] = FrameW'($urandom);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed walks with the directory at the top frame.
    write_dir_base(20'hFFFFF);
    // lowest address, zero length, big page at frame zero
    send_item(ReqNew, 32'h0, 32'h0, 32'h0, 1'b1);
    send_item(ReqResp, 32'h0, 32'h0, 32'h0000_0083, 1'b1);
    // highest address and length on a big page: clip to a single byte
    send_item(ReqNew, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_item(ReqResp, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    // two-level walk to the very last table entry
    send_item(ReqNew, 32'hFFFF_FFFF, 32'h1, 32'h0, 1'b1);
    send_item(ReqResp, 32'h0, 32'h0, 32'hFFFF_F001, 1'b1);
    send_item(ReqResp, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1);
    // directory entry not present
    send_item(ReqNew, 32'h1234_5678, 32'h10, 32'h0, 1'b1);
    send_item(ReqResp, 32'h0, 32'h0, 32'hFFFF_FFFE, 1'b1);
    // table entry not present
    send_item(ReqNew, 32'h8765_4321, 32'h10, 32'h0, 1'b1);
    send_item(ReqResp, 32'h0, 32'h0, 32'h0000_0001, 1'b1);
    send_item(ReqResp, 32'h0, 32'h0, 32'h0000_0000, 1'b1);
    // response with no walk open: ignored
    send_item(ReqResp, 32'h0, 32'h0, 32'h1234_5683, 1'b0);
    // new request drops a walk waiting on the directory
    send_item(ReqNew, 32'h0040_0000, 32'h100, 32'h0, 1'b1);
    send_item(ReqNew, 32'hC03F_FF00, 32'h200, 32'h0, 1'b1);
    send_item(ReqResp, 32'h0, 32'h0, 32'h4000_0081, 1'b1);
    // new request drops a walk waiting on the table
    send_item(ReqNew, 32'h0000_5000, 32'h20, 32'h0, 1'b1);
    send_item(ReqResp, 32'h0, 32'h0, 32'h0000_1001, 1'b1);
    send_item(ReqNew, 32'h0080_0010, 32'h20, 32'h0, 1'b1);
    send_item(ReqResp, 32'h0, 32'h0, 32'h0000_0081, 1'b1);
    // length that ends exactly on the 4KB boundary is not clipped
    send_item(ReqNew, 32'h0000_0F00, 32'h100, 32'h0, 1'b1);
    send_item(ReqResp, 32'h0, 32'h0, 32'h0000_0001, 1'b1);
    send_item(ReqResp, 32'h0, 32'h0, 32'h0000_5001, 1'b1);
    drain();

    // Random walks, one batch per directory base.
    walk_items = 0;
    for (int p = 0; p < PhaseCount; p++) begin
      write_dir_base(frame_plan[p]);
      while (walk_items < (p + 1) * ItemsPerPhase) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          run_walk(1'b0);
        end else if (pick < 85) begin
          // abandon a walk part way, then finish a fresh one
          send_item(ReqNew, pick_vaddr(), pick_vlen(), $urandom, 1'b1);
          if ($urandom_range(0, 1))
            send_item(ReqResp, $urandom, $urandom, pick_entry(1'b0) | 32'h1, 1'b1);
          run_walk(1'b0);
        end else if (pick < 93) begin
          run_walk(1'b1);
        end else begin
          send_item(ReqResp, $urandom, $urandom, $urandom, 1'b0);
        end
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
